>>> hdl/vwd_pkg.sv
`timescale 1ns / 1ps

package vwd_pkg;

  // fixed widths of the result fields, the operation code and the threshold register
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 4;
  localparam int OP_W     = 2;
  localparam int EPS_W    = 34;
  localparam logic [EPS_W-1:0] EPS_RESET = 34'd1;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_FIND     = 2'd1,
    OP_LIST     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROLE_ALONE  = 2'd0,
    ROLE_MASTER = 2'd1,
    ROLE_MEMBER = 2'd2
  } role_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_FOUND    = 4'd0,
    ST_ADDED_ALONE  = 4'd1,
    ST_ADDED_MEMBER = 4'd2,
    ST_PRESENT      = 4'd3,
    ST_FULL         = 4'd4,
    ST_ALONE        = 4'd5,
    ST_MASTER       = 4'd6,
    ST_MEMBER       = 4'd7,
    ST_MATCH        = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_DIST,
    S_WR_NEW,
    S_WR_HEAD,
    S_EMIT,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_LIST,
    S_FINAL
  } state_t;

  // queue head status seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } front_stat_t;

endpackage

>>> hdl/vwd_front.sv
`timescale 1ns / 1ps

module vwd_front #(
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vwd_pkg::OP_W-1:0]     operation,
  input  logic [ID_BITS-1:0]           vertex_id,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output vwd_pkg::front_stat_t         q_stat,
  input  logic                         q_pop,
  output logic [ID_BITS-1:0]           q_id,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  output logic signed [COORD_BITS-1:0] q_z
);

  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  logic       push;

  vwd_pkg::op_t               op_q [2];
  logic [ID_BITS-1:0]         id_q [2];
  logic signed [COORD_BITS-1:0] x_q [2];
  logic signed [COORD_BITS-1:0] y_q [2];
  logic signed [COORD_BITS-1:0] z_q [2];

  // accept while the two-entry queue has room
  assign in_ready = (count != 2'd2);
  assign push     = in_valid & in_ready;

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // classify the operation and store the transaction
  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wptr] <= vwd_pkg::op_t'(operation);
      id_q[wptr] <= vertex_id;
      x_q[wptr]  <= coord_x;
      y_q[wptr]  <= coord_y;
      z_q[wptr]  <= coord_z;
    end
  end

  assign q_stat.valid = (count != 2'd0);
  assign q_stat.op    = op_q[rptr];
  assign q_id         = id_q[rptr];
  assign q_x          = x_q[rptr];
  assign q_y          = y_q[rptr];
  assign q_z          = z_q[rptr];

endmodule

>>> hdl/vwd_back.sv
`timescale 1ns / 1ps

module vwd_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vwd_pkg::EPS_W-1:0]         cfg_data,
  input  vwd_pkg::front_stat_t              q_stat,
  output logic                              q_pop,
  input  logic [ID_BITS-1:0]                q_id,
  input  logic signed [COORD_BITS-1:0]      q_x,
  input  logic signed [COORD_BITS-1:0]      q_y,
  input  logic signed [COORD_BITS-1:0]      q_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vwd_pkg::STATUS_W-1:0]      status,
  output logic [vwd_pkg::SLOT_W-1:0]        head_slot,
  output logic [ID_BITS-1:0]                matched_id,
  output logic                              last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = (PW + 2 > vwd_pkg::EPS_W) ? PW + 2 : vwd_pkg::EPS_W;

  vwd_pkg::state_t state, state_next;

  // table memories
  logic [ID_BITS-1:0]           mem_id   [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] mem_x    [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] mem_y    [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] mem_z    [TABLE_DEPTH];
  vwd_pkg::role_t               mem_role [TABLE_DEPTH];
  logic [AW-1:0]                mem_head [TABLE_DEPTH];

  logic [CW-1:0]                fill;
  logic [vwd_pkg::EPS_W-1:0]    eps;

  // working transaction
  vwd_pkg::op_t                 w_op;
  logic [ID_BITS-1:0]           w_id;
  logic signed [COORD_BITS-1:0] w_x, w_y, w_z;

  // lookup results
  logic                         found;
  logic [AW-1:0]                slot;
  vwd_pkg::role_t               s_role;
  logic [AW-1:0]                s_head;
  logic [AW-1:0]                head_reg;
  logic                         m_found;
  vwd_pkg::role_t               m_role;

  // scan pipeline
  logic [CW-1:0]                rd_addr;
  logic                         a_vld;
  logic [AW-1:0]                a_addr;
  logic [ID_BITS-1:0]           a_id;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
  vwd_pkg::role_t               a_role;
  logic [AW-1:0]                a_head;
  logic                         b_vld;
  logic [AW-1:0]                b_addr;
  vwd_pkg::role_t               b_role;
  logic [DW-1:0]                b_dx, b_dy, b_dz;
  logic                         c_vld;
  logic [AW-1:0]                c_addr;
  vwd_pkg::role_t               c_role;
  logic [PW-1:0]                c_sx, c_sy, c_sz;

  // pending list entry and output register
  logic                         pend_vld;
  logic [ID_BITS-1:0]           pend_id;
  logic                         o_vld;
  vwd_pkg::status_t             o_status;
  logic [vwd_pkg::SLOT_W-1:0]   o_head;
  logic [ID_BITS-1:0]           o_id;
  logic                         o_last;
  vwd_pkg::status_t             res_status;
  logic [AW-1:0]                res_head;

  // control strobes
  logic                         scan_on;
  logic                         iss;
  logic                         adv;
  logic                         scan_start;
  logic                         out_free;
  logic                         a_hit_id;
  logic                         list_hit;
  logic                         dist_hit;
  logic                         a_empty;
  logic                         dist_done;
  logic [SW-1:0]                dist_sum;
  logic [AW-1:0]                rd_sel;
  logic                         push;
  vwd_pkg::status_t             push_status;
  logic [AW-1:0]                push_head;
  logic [ID_BITS-1:0]           push_id;
  logic                         push_last;
  vwd_pkg::status_t             dec_status;
  logic [AW-1:0]                dec_head;
  logic                         wr_new;
  logic                         wr_master;

  function automatic logic [DW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] p,
                                             input logic signed [COORD_BITS-1:0] q);
    logic signed [DW-1:0] d;
    d = DW'(p) - DW'(q);
    abs_diff = d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // scan status
  assign scan_on  = (state == vwd_pkg::S_FIND) || (state == vwd_pkg::S_DIST) ||
                    (state == vwd_pkg::S_LIST);
  assign iss      = scan_on && (rd_addr < fill);
  assign out_free = !o_vld || out_ready;
  assign a_hit_id = a_vld && (a_id == w_id);
  assign list_hit = a_vld && (a_role == vwd_pkg::ROLE_MEMBER) && (a_head == head_reg) &&
                    (a_addr != slot);
  assign dist_sum = SW'(c_sx) + SW'(c_sy) + SW'(c_sz);
  assign dist_hit = c_vld && (c_role != vwd_pkg::ROLE_MEMBER) && (dist_sum < SW'(eps));
  assign a_empty  = !iss && !a_vld;
  assign dist_done = a_empty && !b_vld && !c_vld;
  assign rd_sel   = (state == vwd_pkg::S_HEAD_RD) ? head_reg : rd_addr[AW-1:0];

  // decision after the id lookup
  always_comb begin
    dec_status = vwd_pkg::ST_NOT_FOUND;
    dec_head   = '0;
    case (w_op)
      vwd_pkg::OP_REGISTER: begin
        if (found) dec_status = vwd_pkg::ST_PRESENT;
        else dec_status = vwd_pkg::ST_FULL;
      end
      vwd_pkg::OP_FIND: begin
        if (found) begin
          case (s_role)
            vwd_pkg::ROLE_MEMBER: begin
              dec_status = vwd_pkg::ST_MEMBER;
              dec_head   = s_head;
            end
            vwd_pkg::ROLE_MASTER: dec_status = vwd_pkg::ST_MASTER;
            default: dec_status = vwd_pkg::ST_ALONE;
          endcase
        end
      end
      vwd_pkg::OP_LIST: begin
        if (found) dec_status = vwd_pkg::ST_ALONE;
      end
      default: dec_status = vwd_pkg::ST_NOT_FOUND;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vwd_pkg::S_IDLE: if (q_stat.valid) state_next = vwd_pkg::S_FIND;
      vwd_pkg::S_FIND: if (a_hit_id || a_empty) state_next = vwd_pkg::S_DECIDE;
      vwd_pkg::S_DECIDE: begin
        case (w_op)
          vwd_pkg::OP_REGISTER: begin
            if (found || (fill == CW'(TABLE_DEPTH))) state_next = vwd_pkg::S_EMIT;
            else state_next = vwd_pkg::S_DIST;
          end
          vwd_pkg::OP_LIST: begin
            if (!found || (s_role == vwd_pkg::ROLE_ALONE)) state_next = vwd_pkg::S_EMIT;
            else if (s_role == vwd_pkg::ROLE_MASTER) state_next = vwd_pkg::S_LIST;
            else state_next = vwd_pkg::S_HEAD_RD;
          end
          default: state_next = vwd_pkg::S_EMIT;
        endcase
      end
      vwd_pkg::S_DIST: if (dist_hit || dist_done) state_next = vwd_pkg::S_WR_NEW;
      vwd_pkg::S_WR_NEW: begin
        if (m_found && (m_role == vwd_pkg::ROLE_ALONE)) state_next = vwd_pkg::S_WR_HEAD;
        else state_next = vwd_pkg::S_EMIT;
      end
      vwd_pkg::S_WR_HEAD: state_next = vwd_pkg::S_EMIT;
      vwd_pkg::S_EMIT: if (out_free) state_next = vwd_pkg::S_IDLE;
      vwd_pkg::S_HEAD_RD: state_next = vwd_pkg::S_HEAD_WAIT;
      vwd_pkg::S_HEAD_WAIT: state_next = vwd_pkg::S_LIST;
      vwd_pkg::S_LIST: if (!list_hit && a_empty) state_next = vwd_pkg::S_FINAL;
      vwd_pkg::S_FINAL: if (out_free) state_next = vwd_pkg::S_IDLE;
      default: state_next = vwd_pkg::S_IDLE;
    endcase
  end

  // output strobes
  always_comb begin
    q_pop       = 1'b0;
    scan_start  = 1'b0;
    adv         = 1'b0;
    push        = 1'b0;
    push_status = vwd_pkg::ST_NOT_FOUND;
    push_head   = '0;
    push_id     = '0;
    push_last   = 1'b1;
    wr_new      = 1'b0;
    wr_master   = 1'b0;
    case (state)
      vwd_pkg::S_IDLE: begin
        q_pop      = q_stat.valid;
        scan_start = q_stat.valid;
      end
      vwd_pkg::S_FIND: adv = 1'b1;
      vwd_pkg::S_DECIDE: scan_start = 1'b1;
      vwd_pkg::S_DIST: adv = 1'b1;
      vwd_pkg::S_WR_NEW: wr_new = 1'b1;
      vwd_pkg::S_WR_HEAD: wr_master = 1'b1;
      vwd_pkg::S_EMIT: begin
        push        = out_free;
        push_status = res_status;
        push_head   = res_head;
      end
      vwd_pkg::S_HEAD_RD: adv = 1'b1;
      vwd_pkg::S_HEAD_WAIT: scan_start = 1'b1;
      vwd_pkg::S_LIST: begin
        adv         = !(list_hit && pend_vld && !out_free);
        push        = list_hit && pend_vld && out_free;
        push_status = vwd_pkg::ST_MATCH;
        push_head   = head_reg;
        push_id     = pend_id;
        push_last   = 1'b0;
      end
      vwd_pkg::S_FINAL: begin
        push = out_free;
        if (pend_vld) begin
          push_status = vwd_pkg::ST_MATCH;
          push_head   = head_reg;
          push_id     = pend_id;
        end
      end
      default: adv = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vwd_pkg::S_IDLE;
      fill     <= '0;
      eps      <= vwd_pkg::EPS_RESET;
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      c_vld    <= 1'b0;
      pend_vld <= 1'b0;
      o_vld    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) eps <= cfg_data;
      if (wr_new) fill <= fill + 1'b1;
      if (scan_start) begin
        a_vld <= 1'b0;
        b_vld <= 1'b0;
        c_vld <= 1'b0;
      end else if (adv) begin
        a_vld <= iss;
        b_vld <= a_vld;
        c_vld <= b_vld;
      end
      // the last pending entry is kept until the final transaction leaves
      if (state == vwd_pkg::S_DECIDE || (state == vwd_pkg::S_FINAL && out_free))
        pend_vld <= 1'b0;
      else if (state == vwd_pkg::S_HEAD_WAIT) pend_vld <= 1'b1;
      else if (state == vwd_pkg::S_LIST && list_hit && adv) pend_vld <= 1'b1;
      if (push) o_vld <= 1'b1;
      else if (out_ready) o_vld <= 1'b0;
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (scan_start) rd_addr <= '0;
    else if (adv && iss) rd_addr <= rd_addr + 1'b1;
  end

  // working transaction and lookup results
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_op  <= q_stat.op;
      w_id  <= q_id;
      w_x   <= q_x;
      w_y   <= q_y;
      w_z   <= q_z;
      found <= 1'b0;
    end
    if (state == vwd_pkg::S_FIND && a_hit_id) begin
      found  <= 1'b1;
      slot   <= a_addr;
      s_role <= a_role;
      s_head <= a_head;
    end
    if (state == vwd_pkg::S_DECIDE) begin
      res_status <= dec_status;
      res_head   <= dec_head;
      m_found    <= 1'b0;
      head_reg   <= (s_role == vwd_pkg::ROLE_MASTER) ? slot : s_head;
    end
    if (state == vwd_pkg::S_DIST && dist_hit) begin
      m_found  <= 1'b1;
      m_role   <= c_role;
      head_reg <= c_addr;
    end
    if (wr_new) begin
      res_status <= m_found ? vwd_pkg::ST_ADDED_MEMBER : vwd_pkg::ST_ADDED_ALONE;
      res_head   <= m_found ? head_reg : '0;
    end
    if (state == vwd_pkg::S_HEAD_WAIT) pend_id <= a_id;
    else if (state == vwd_pkg::S_LIST && list_hit && adv) pend_id <= a_id;
  end

  // memory read into the first scan stage
  always_ff @(posedge clk) begin
    if (adv) begin
      a_addr <= rd_sel;
      a_id   <= mem_id[rd_sel];
      a_x    <= mem_x[rd_sel];
      a_y    <= mem_y[rd_sel];
      a_z    <= mem_z[rd_sel];
      a_role <= mem_role[rd_sel];
      a_head <= mem_head[rd_sel];
    end
  end

  // memory writes: new entry, then head promotion
  always_ff @(posedge clk) begin
    if (wr_new) begin
      mem_id[fill[AW-1:0]]   <= w_id;
      mem_x[fill[AW-1:0]]    <= w_x;
      mem_y[fill[AW-1:0]]    <= w_y;
      mem_z[fill[AW-1:0]]    <= w_z;
      mem_role[fill[AW-1:0]] <= m_found ? vwd_pkg::ROLE_MEMBER : vwd_pkg::ROLE_ALONE;
      mem_head[fill[AW-1:0]] <= m_found ? head_reg : '0;
    end else if (wr_master) begin
      mem_role[head_reg] <= vwd_pkg::ROLE_MASTER;
    end
  end

  // distance pipeline: absolute differences, then squares
  always_ff @(posedge clk) begin
    if (adv) begin
      b_addr <= a_addr;
      b_role <= a_role;
      b_dx   <= abs_diff(a_x, w_x);
      b_dy   <= abs_diff(a_y, w_y);
      b_dz   <= abs_diff(a_z, w_z);
      c_addr <= b_addr;
      c_role <= b_role;
      c_sx   <= PW'(b_dx) * PW'(b_dx);
      c_sy   <= PW'(b_dy) * PW'(b_dy);
      c_sz   <= PW'(b_dz) * PW'(b_dz);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (push) begin
      o_status <= push_status;
      o_head   <= vwd_pkg::SLOT_W'(push_head);
      o_id     <= push_id;
      o_last   <= push_last;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_valid  = o_vld;
  assign status     = o_status;
  assign head_slot  = o_head;
  assign matched_id = o_id;
  assign last       = o_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (state != vwd_pkg::S_WR_NEW) |=> $stable(fill))
    else $error("fill count moved outside an entry write");

  a_promote_order: assert property (@(posedge clk) disable iff (rst)
    (state == vwd_pkg::S_WR_HEAD) |-> ($past(state) == vwd_pkg::S_WR_NEW))
    else $error("head promotion without a new member write");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> (state == vwd_pkg::S_LIST || state == vwd_pkg::S_FINAL))
    else $error("pending listing entry outside a listing");

endmodule

>>> hdl/vertex_weld_dictionary_top.sv
`timescale 1ns / 1ps
// register does an id scan, then a distance scan, over the N entries stored
// find does an id scan; list does an id scan, then a member scan that output stalls can hold
// throughput: one transaction at a time in the back end, set by the single-port table scan
// a two-entry input queue keeps accepting while the back end works, as long as it has room
// synchronous active-high reset empties the table (fill count 0) and sets epsilon_sq to 1
module vertex_weld_dictionary_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vwd_pkg::EPS_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vwd_pkg::OP_W-1:0]     operation,
  input  logic [ID_BITS-1:0]           vertex_id,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vwd_pkg::STATUS_W-1:0] status,
  output logic [vwd_pkg::SLOT_W-1:0]   head_slot,
  output logic [ID_BITS-1:0]           matched_id,
  output logic                         last
);

  vwd_pkg::front_stat_t         q_stat;
  logic                         q_pop;
  logic [ID_BITS-1:0]           q_id;
  logic signed [COORD_BITS-1:0] q_x, q_y, q_z;

  // input queue and classification
  vwd_front #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .vertex_id(vertex_id),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .coord_z  (coord_z),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .q_id     (q_id),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_z      (q_z)
  );

  // table scans and results
  vwd_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_id      (q_id),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_z       (q_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .head_slot (head_slot),
    .matched_id(matched_id),
    .last      (last)
  );

endmodule
